// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Result tdata layout, from the lowest bit up.
    localparam int OUT_VALUE_LSB  = 0;
    localparam int OUT_STATUS_LSB = OUT_VALUE_LSB + VALUE_W;
    localparam int OUT_EMPTY_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_FILL_LSB   = OUT_EMPTY_LSB + 1;
    localparam int OUT_BITS       = OUT_FILL_LSB + FILL_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== hdl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top: double-ended queue in a ring buffer
// Push, pop and peek at either end of a ring of DEPTH words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per transfer: tuser holds the
//   operation code and tdata the word to push. For every operation exactly
//   one result leaves on the master stream with the popped or peeked word,
//   a status code, an empty flag and the fill count after the operation.
//   Pops and peeks on an empty queue return an empty error, pushes into a
//   full ring return a full status; in both cases the state is unchanged.
//   Each result passes the pending stage and then the output register. A
//   new operation is taken once the last result has left the pending stage:
//   the ring memory is read in the accept cycle and its registered read
//   data is folded into the result when the output register is free.
//   When the receiver stalls, the result waits in the output register; the
//   next operation is still taken and its result waits in the pending
//   stage, after which tready stays low until the output drains.
//   Reset empties the queue (front index and count go to zero) and drops
//   any result in flight. The ring contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // value (32)
    input  logic [deq_pkg::VALUE_W-1:0]      i_s_tdata,
    // kind (3)
    input  logic [deq_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // value_out (32), status (2), is_empty (1), fill (5)
    output logic [deq_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_HOLD
    } t_state;

    t_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_ring [DEPTH];

    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_pend_use_rd;
    logic [deq_pkg::STATUS_W-1:0] r_pend_status;
    logic [CW-1:0]         r_pend_count;

    logic                         r_out_valid;
    logic [deq_pkg::VALUE_W-1:0]  r_out_value;
    logic [deq_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_empty;
    logic [deq_pkg::FILL_W-1:0]   r_out_fill;

    logic                         accept;
    logic                         out_free;
    logic [IW-1:0]                front_dec;
    logic [IW-1:0]                front_inc;
    logic [SW-1:0]                tail_sum;
    logic [IW-1:0]                tail_idx;
    logic [SW-1:0]                back_sum;
    logic [IW-1:0]                back_idx;
    logic                         is_full;
    logic                         is_empty;
    logic                         do_write;
    logic [IW-1:0]                wr_addr;
    logic                         do_read;
    logic [IW-1:0]                rd_addr;
    logic [deq_pkg::STATUS_W-1:0] op_status;
    logic [CW-1:0]                op_count;
    logic [IW-1:0]                op_front;
    logic [63:0]                  wr_wide;
    logic [63:0]                  rd_wide;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;

    assign is_full  = (r_count >= DEPTH_C);
    assign is_empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? LAST_I : r_front - IW'(1);
    assign front_inc = (r_front == LAST_I) ? '0 : r_front + IW'(1);

    // Ring positions: both sums stay below twice the depth, so one
    // conditional subtract wraps them.
    assign tail_sum = SW'(r_front) + SW'(r_count);
    assign tail_idx = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
    assign back_sum = tail_sum - SW'(1);
    assign back_idx = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);

    always_comb begin
        do_write  = 1'b0;
        wr_addr   = tail_idx;
        do_read   = 1'b0;
        rd_addr   = r_front;
        op_status = deq_pkg::STATUS_OK;
        op_count  = r_count;
        op_front  = r_front;
        unique case (i_s_tuser)
            deq_pkg::KIND_PUSH_FRONT: begin
                if (is_full) begin
                    op_status = deq_pkg::STATUS_FULL;
                end else begin
                    do_write = 1'b1;
                    wr_addr  = front_dec;
                    op_front = front_dec;
                    op_count = r_count + CW'(1);
                end
            end
            deq_pkg::KIND_PUSH_BACK: begin
                if (is_full) begin
                    op_status = deq_pkg::STATUS_FULL;
                end else begin
                    do_write = 1'b1;
                    op_count = r_count + CW'(1);
                end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
                if (is_empty) begin
                    op_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    do_read = 1'b1;
                    if (i_s_tuser == deq_pkg::KIND_POP_FRONT) begin
                        op_front = front_inc;
                        op_count = r_count - CW'(1);
                    end
                end
            end
            deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
                if (is_empty) begin
                    op_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    do_read = 1'b1;
                    rd_addr = back_idx;
                    if (i_s_tuser == deq_pkg::KIND_POP_BACK) begin
                        op_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        // An empty queue always restarts at the first entry.
        if (op_count == '0) begin
            op_front = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_HOLD;
                    n_front = op_front;
                    n_count = op_count;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (r_state == ST_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign wr_wide = {32'b0, i_s_tdata};
    assign rd_wide = 64'(r_rd_data);

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (accept && do_write) begin
            r_ring[wr_addr] <= wr_wide[DATA_WIDTH-1:0];
        end
        if (accept && do_read) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_use_rd <= do_read;
            r_pend_status <= op_status;
            r_pend_count  <= op_count;
        end
        if (r_state == ST_HOLD && out_free) begin
            r_out_value  <= r_pend_use_rd ? rd_wide[deq_pkg::VALUE_W-1:0] : '0;
            r_out_status <= r_pend_status;
            r_out_empty  <= (r_pend_count == '0);
            r_out_fill   <= deq_pkg::FILL_W'(32'(r_pend_count));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = deq_pkg::OUT_TDATA_W'({r_out_fill, r_out_empty,
                                               r_out_status, r_out_value});

endmodule

// ===== hdl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the stream ports of the top level; attached by a bind statement.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [deq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic [deq_pkg::VALUE_W-1:0]  out_value;
    logic [deq_pkg::STATUS_W-1:0] out_status;
    logic                         out_empty;
    logic [deq_pkg::FILL_W-1:0]   out_fill;

    assign out_value  = o_m_tdata[deq_pkg::OUT_VALUE_LSB +: deq_pkg::VALUE_W];
    assign out_status = o_m_tdata[deq_pkg::OUT_STATUS_LSB +: deq_pkg::STATUS_W];
    assign out_empty  = o_m_tdata[deq_pkg::OUT_EMPTY_LSB];
    assign out_fill   = o_m_tdata[deq_pkg::OUT_FILL_LSB +: deq_pkg::FILL_W];

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Errors never carry a data word.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_status != deq_pkg::STATUS_OK |-> out_value == '0)
        else $error("error result carries a data word");

    // The empty flag agrees with the fill count while the count fits the field.
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (DEPTH >= 32) || (out_empty == (out_fill == '0)))
        else $error("empty flag disagrees with fill count");

    // One operation at a time: no transfer in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready in the cycle after a transfer");

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
